// ----- rtl/core/bcsr_pkg.sv -----
`timescale 1ns / 1ps

package bcsr_pkg;

  // Field and register widths.
  localparam int TOK_W      = 16;
  localparam int HID_W      = 10;
  localparam int ROWS_W     = 10;
  localparam int COLS_W     = 11;
  localparam int ROW_W      = 30;
  localparam int COL_W      = 24;
  localparam int CNT_W      = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 11;

  // Serial divider: the numerator covers token_count plus block_cols minus one.
  localparam int DIV_NUM_W  = TOK_W + 1;
  localparam int DIV_DEN_W  = COLS_W;
  localparam int DIV_STEP_W = $clog2(DIV_NUM_W);

  // Block row count: at most MAX_ROWS rows per expert.
  localparam int MAX_ROWS       = 64;
  localparam int R_W            = $clog2(MAX_ROWS) + 1;
  localparam int RIDX_W         = $clog2(MAX_ROWS);
  localparam int MIN_BLOCK_ROWS = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_ROWS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_COLS = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_G,
    ST_DIV_R,
    ST_EMIT
  } bcsr_state_t;

  typedef struct packed {
    logic load_item;
    logic cap_g;
    logic start_div_r;
    logic cap_r;
    logic bump_base;
    logic emit_row;
  } bcsr_cmd_t;

  typedef struct packed {
    logic div_done;
    logic r_zero;
    logic row_last;
    logic out_free;
  } bcsr_status_t;

endpackage

// ----- rtl/core/bcsr_div.sv -----
`timescale 1ns / 1ps

module bcsr_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [bcsr_pkg::DIV_NUM_W-1:0] num,
  input  logic [bcsr_pkg::DIV_DEN_W-1:0] den,
  output logic                           done,
  output logic [bcsr_pkg::DIV_NUM_W-1:0] quot
);
  import bcsr_pkg::*;

  localparam logic [DIV_STEP_W-1:0] LAST_STEP = DIV_STEP_W'(DIV_NUM_W - 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_STEP_W-1:0] step_r, step_nxt;
  logic [DIV_NUM_W-1:0]  q_r, q_nxt;
  logic [DIV_DEN_W-1:0]  rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0]  den_r, den_nxt;
  logic [DIV_DEN_W:0]    shifted;
  logic [DIV_DEN_W:0]    diff;

  // Restoring division, one quotient bit per cycle. The numerator shifts out
  // of q_r at the top while quotient bits enter at the bottom.
  always_comb begin
    shifted  = {rem_r, q_r[DIV_NUM_W-1]};
    diff     = shifted - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = diff[DIV_DEN_W-1:0];
        q_nxt   = {q_r[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DIV_DEN_W-1:0];
        q_nxt   = {q_r[DIV_NUM_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ----- rtl/core/bcsr_datapath.sv -----
`timescale 1ns / 1ps

module bcsr_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bcsr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bcsr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_first_expert,
  input  logic [bcsr_pkg::TOK_W-1:0]      in_token_count,
  input  logic [bcsr_pkg::HID_W-1:0]      in_hidden_dim,
  input  bcsr_pkg::bcsr_cmd_t             cmd,
  output bcsr_pkg::bcsr_status_t          status,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bcsr_pkg::ROW_W-1:0]      out_row_end,
  output logic [bcsr_pkg::COL_W-1:0]      out_first_col,
  output logic [bcsr_pkg::CNT_W-1:0]      out_col_count,
  output logic                            out_last
);
  import bcsr_pkg::*;

  logic [ROWS_W-1:0]    block_rows_r;
  logic [COLS_W-1:0]    block_cols_r;
  logic [ROW_W-1:0]     row_offset_r;
  logic [COL_W-1:0]     column_base_r;
  logic [HID_W-1:0]     hidden_r;
  logic [CNT_W-1:0]     g_r;
  logic [R_W-1:0]       r_r;
  logic [RIDX_W-1:0]    row_idx_r;
  logic                 out_valid_r;
  logic [ROW_W-1:0]     out_row_end_r;
  logic [COL_W-1:0]     out_first_col_r;
  logic [CNT_W-1:0]     out_col_count_r;
  logic                 out_last_r;

  logic [COLS_W-1:0]    kx;
  logic [ROWS_W-1:0]    ky;
  logic [DIV_NUM_W-1:0] num_g;
  logic [HID_W:0]       num_r_short;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_start;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_q;
  logic [R_W-1:0]       r_clamped;
  logic [ROW_W-1:0]     row_sum;
  logic                 row_last;

  // Out-of-range block sizes fall back to the smallest legal size.
  assign kx = (block_cols_r == '0) ? COLS_W'(1) : block_cols_r;
  assign ky = (block_rows_r < ROWS_W'(MIN_BLOCK_ROWS)) ? ROWS_W'(MIN_BLOCK_ROWS) : block_rows_r;

  // Ceiling division as floor((n + d - 1) / d); a zero count still yields zero.
  assign num_g       = {1'b0, in_token_count} + DIV_NUM_W'(kx) - DIV_NUM_W'(1);
  assign num_r_short = {1'b0, hidden_r} + (HID_W + 1)'(ky) - (HID_W + 1)'(1);

  assign div_start = cmd.load_item | cmd.start_div_r;
  assign div_num   = cmd.load_item ? num_g : DIV_NUM_W'(num_r_short);
  assign div_den   = cmd.load_item ? kx : DIV_DEN_W'(ky);

  bcsr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  assign r_clamped = (div_q > DIV_NUM_W'(MAX_ROWS)) ? R_W'(MAX_ROWS) : div_q[R_W-1:0];
  assign row_sum   = row_offset_r + ROW_W'(g_r);
  assign row_last  = (R_W'(row_idx_r) + R_W'(1)) == r_r;

  assign status.div_done = div_done;
  assign status.r_zero   = (div_q == '0);
  assign status.row_last = row_last;
  assign status.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_rows_r  <= ROWS_W'(MIN_BLOCK_ROWS);
      block_cols_r  <= COLS_W'(1);
      row_offset_r  <= '0;
      column_base_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we && cfg_addr == CFG_BLOCK_ROWS) begin
        block_rows_r <= cfg_wdata[ROWS_W-1:0];
      end
      if (cfg_we && cfg_addr == CFG_BLOCK_COLS) begin
        block_cols_r <= cfg_wdata[COLS_W-1:0];
      end
      if (cmd.load_item && in_first_expert) begin
        row_offset_r  <= '0;
        column_base_r <= '0;
      end
      if (cmd.emit_row) begin
        row_offset_r <= row_sum;
      end
      // The column base moves on once the expert's rows are done, or at
      // once when the expert has no rows at all.
      if (cmd.bump_base || (cmd.emit_row && row_last)) begin
        column_base_r <= column_base_r + COL_W'(g_r);
      end
      if (cmd.emit_row) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      hidden_r <= in_hidden_dim;
    end
    if (cmd.cap_g) begin
      g_r <= div_q[CNT_W-1:0];
    end
    if (cmd.cap_r) begin
      r_r       <= r_clamped;
      row_idx_r <= '0;
    end else if (cmd.emit_row) begin
      row_idx_r <= row_idx_r + 1'b1;
    end
    if (cmd.emit_row) begin
      out_row_end_r   <= row_sum;
      out_first_col_r <= column_base_r;
      out_col_count_r <= g_r;
      out_last_r      <= row_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_end   = out_row_end_r;
  assign out_first_col = out_first_col_r;
  assign out_col_count = out_col_count_r;
  assign out_last      = out_last_r;

endmodule

// ----- rtl/core/bcsr_ctrl.sv -----
`timescale 1ns / 1ps

module bcsr_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  bcsr_pkg::bcsr_status_t status,
  output bcsr_pkg::bcsr_cmd_t    cmd
);
  import bcsr_pkg::*;

  bcsr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = !rst_n || (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_DIV_G;
        end
      end
      ST_DIV_G: begin
        if (status.div_done) begin
          cmd.cap_g       = 1'b1;
          cmd.start_div_r = 1'b1;
          state_nxt       = ST_DIV_R;
        end
      end
      ST_DIV_R: begin
        if (status.div_done) begin
          cmd.cap_r = 1'b1;
          if (status.r_zero) begin
            cmd.bump_base = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit_row = 1'b1;
          if (status.row_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/block_csr_builder.sv -----
`timescale 1ns / 1ps

// Block-sparse CSR builder, one expert per input word.
// Input channel (in_*): first_expert, token_count and hidden_dim of one expert.
// A word is taken when in_valid is high and in_stall is low. first_expert set
// restarts the row pointer and the column base at zero before this expert.
// Result channel (out_*): one word per block row of the expert, carrying the
// running row pointer, the first global column, the column count and a last
// flag on the expert's final row. An expert with zero hidden dimension gives
// no words but still advances the column base.
// Configuration (cfg_*): block_rows at index 0, block_cols at index 1; the user
// must write them only while the block is idle, which the block does not enforce.
// Timing: both ceiling divisions run on one shared serial divider, one bit per
// cycle, 17 steps each; the second starts when the first is done, and the first
// row word follows it. Rows then follow one per cycle while out_stall is low. The
// next input word is taken only once the expert's divisions and row words are done.
// A stalled result word holds; the row sequencer waits for it and the divider
// for the next expert runs while the final word of the previous one waits.
// Reset (synchronous, active low) restores block_rows 16 and block_cols 1,
// clears both accumulators and drops out_valid.
module block_csr_builder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bcsr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bcsr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_first_expert,
  input  logic [bcsr_pkg::TOK_W-1:0]      in_token_count,
  input  logic [bcsr_pkg::HID_W-1:0]      in_hidden_dim,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bcsr_pkg::ROW_W-1:0]      out_row_end,
  output logic [bcsr_pkg::COL_W-1:0]      out_first_col,
  output logic [bcsr_pkg::CNT_W-1:0]      out_col_count,
  output logic                            out_last
);
  import bcsr_pkg::*;

  bcsr_cmd_t    cmd;
  bcsr_status_t status;

  bcsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  bcsr_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_first_expert (in_first_expert),
    .in_token_count  (in_token_count),
    .in_hidden_dim   (in_hidden_dim),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_end     (out_row_end),
    .out_first_col   (out_first_col),
    .out_col_count   (out_col_count),
    .out_last        (out_last)
  );

endmodule

// ----- rtl/core/bcsr_checker.sv -----
`timescale 1ns / 1ps

module bcsr_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [bcsr_pkg::ROW_W-1:0] out_row_end,
  input logic [bcsr_pkg::COL_W-1:0] out_first_col,
  input logic [bcsr_pkg::CNT_W-1:0] out_col_count,
  input logic                       out_last
);
  import bcsr_pkg::*;

  // A stalled result word stays valid and unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_row_end)
      && $stable(out_first_col) && $stable(out_col_count) && $stable(out_last)))
    else $error("stalled result word changed");

  // The divisions keep the input closed right after a word is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall ##1 in_stall)
    else $error("input taken while divisions run");

  // Rows of one expert follow without a gap and share column base and count.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=> (out_valid
      && out_first_col == $past(out_first_col) && out_col_count == $past(out_col_count)))
    else $error("row sequence of one expert broken");

  // Reset drops any pending result word.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind block_csr_builder bcsr_checker u_bcsr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_row_end   (out_row_end),
  .out_first_col (out_first_col),
  .out_col_count (out_col_count),
  .out_last      (out_last)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import bcsr_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 60;   // divider latency of an expert plus slack
  localparam int HOLD_AT_ROW = 2000;
  localparam int HOLD_CYCLES = 500;
  localparam int MAX_SHOWN = 30;

  typedef struct packed {
    logic [ROW_W-1:0] row_end;
    logic [COL_W-1:0] first_col;
    logic [CNT_W-1:0] col_count;
    logic             last;
  } row_word_t;

  // Tracks the row pointer and column base and holds the row words still due.
  class csr_row_tracker;
    row_word_t         rows_due[$];
    logic [ROWS_W-1:0] block_rows;
    logic [COLS_W-1:0] block_cols;
    logic [ROW_W-1:0]  row_ptr;
    logic [COL_W-1:0]  col_base;
    int                errors;

    function new();
      block_rows = ROWS_W'(16);
      block_cols = COLS_W'(1);
      row_ptr = '0;
      col_base = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      if (addr == CFG_BLOCK_ROWS) begin
        block_rows = data[ROWS_W-1:0];
      end else if (addr == CFG_BLOCK_COLS) begin
        block_cols = data[COLS_W-1:0];
      end
    endfunction

    function int waiting();
      return rows_due.size();
    endfunction

    // Works out the block rows of one accepted expert.
    function void take_expert(bit first, logic [TOK_W-1:0] tokens, logic [HID_W-1:0] hidden);
      int unsigned ky;
      int unsigned kx;
      int unsigned g;
      int unsigned r;
      int unsigned i;
      row_word_t   word;
      ky = (block_rows < MIN_BLOCK_ROWS) ? MIN_BLOCK_ROWS : block_rows;
      kx = (block_cols == 0) ? 1 : block_cols;
      if (first) begin
        row_ptr = '0;
        col_base = '0;
      end
      g = (tokens == 0) ? 0 : (tokens + kx - 1) / kx;
      g = g & 32'hFFFF;
      r = (hidden == 0) ? 0 : (hidden + ky - 1) / ky;
      if (r > MAX_ROWS) r = MAX_ROWS;
      for (i = 0; i < r; i++) begin
        row_ptr = row_ptr + g[ROW_W-1:0];
        word.row_end = row_ptr;
        word.first_col = col_base;
        word.col_count = g[CNT_W-1:0];
        word.last = (i + 1 == r);
        rows_due.insert(rows_due.size(), word);
      end
      // The column base moves on even for an expert with no rows.
      col_base = col_base + g[COL_W-1:0];
    endfunction

    task flag(string msg);
      // Only the first few mismatches are shown; all of them count.
      if (errors < MAX_SHOWN) $display("mismatch: %s", msg);
      errors++;
    endtask

    task match_row(row_word_t got);
      row_word_t want;
      if (rows_due.size() == 0) begin
        flag($sformatf("row word %h arrived with none due", got));
        return;
      end
      want = rows_due.pop_front();
      if (got.row_end !== want.row_end)
        flag($sformatf("row_end %0d, expected %0d", got.row_end, want.row_end));
      if (got.first_col !== want.first_col)
        flag($sformatf("first_col %0d, expected %0d", got.first_col, want.first_col));
      if (got.col_count !== want.col_count)
        flag($sformatf("col_count %0d, expected %0d", got.col_count, want.col_count));
      if (got.last !== want.last)
        flag($sformatf("last %0d, expected %0d", got.last, want.last));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_first_expert;
  logic [TOK_W-1:0]      in_token_count;
  logic [HID_W-1:0]      in_hidden_dim;
  logic                  out_valid;
  logic                  out_stall;
  logic [ROW_W-1:0]      out_row_end;
  logic [COL_W-1:0]      out_first_col;
  logic [CNT_W-1:0]      out_col_count;
  logic                  out_last;

  csr_row_tracker tracker = new();
  bit             quiet = 1'b0;
  int unsigned    rows_seen = 0;
  int unsigned    cycles = 0;

  block_csr_builder DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_first_expert (in_first_expert),
    .in_token_count  (in_token_count),
    .in_hidden_dim   (in_hidden_dim),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_end     (out_row_end),
    .out_first_col   (out_first_col),
    .out_col_count   (out_col_count),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: checks accepted row words and stalls at random, with one long hold.
  initial begin : result_side
    int unsigned hold_left;
    bit          held;
    row_word_t   got;
    hold_left = 0;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall == 1'b0) begin
        got.row_end = out_row_end;
        got.first_col = out_first_col;
        got.col_count = out_col_count;
        got.last = out_last;
        tracker.match_row(got);
        rows_seen++;
      end
      if (!held && rows_seen >= HOLD_AT_ROW) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 27);
      end
    end
  end

  task automatic send_expert(input bit first, input logic [TOK_W-1:0] tokens,
                             input logic [HID_W-1:0] hidden);
    while (!quiet && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_first_expert <= first;
    in_token_count <= tokens;
    in_hidden_dim <= hidden;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    tracker.take_expert(first, tokens, hidden);
  endtask

  // Waits until every row word has come, then lets a trailing expert finish.
  task automatic drain(input int extra);
    in_valid <= 1'b0;
    while (tracker.waiting() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_blocks(input logic [CFG_DATA_W-1:0] rows_val,
                            input logic [CFG_DATA_W-1:0] cols_val);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_BLOCK_ROWS;
    cfg_wdata <= rows_val;
    @(posedge clk);
    tracker.write_reg(CFG_BLOCK_ROWS, rows_val);
    cfg_addr <= CFG_BLOCK_COLS;
    cfg_wdata <= cols_val;
    @(posedge clk);
    tracker.write_reg(CFG_BLOCK_COLS, cols_val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Expert sequences with random content; a new sequence starts now and then.
  task automatic run_mixed(input int count);
    int               n;
    bit               first;
    logic [TOK_W-1:0] tokens;
    logic [HID_W-1:0] hidden;
    for (n = 0; n < count; n++) begin
      first = (n == 0) || ($urandom_range(9) == 0);
      case ($urandom_range(7))
        0: tokens = '0;
        1: tokens = '1;
        default: tokens = TOK_W'($urandom_range(65535));
      endcase
      hidden = ($urandom_range(7) == 0) ? '0 : HID_W'($urandom_range(1023));
      send_expert(first, tokens, hidden);
    end
  endtask

  // One long sequence of heavy experts, long enough for both accumulators to wrap.
  task automatic run_heavy(input int count);
    int               n;
    logic [TOK_W-1:0] tokens;
    logic [HID_W-1:0] hidden;
    for (n = 0; n < count; n++) begin
      quiet = (n >= 100 && n < 180);
      tokens = ($urandom_range(9) == 0) ? TOK_W'($urandom_range(65535))
                                        : TOK_W'($urandom_range(65535, 64000));
      hidden = ($urandom_range(9) == 0) ? HID_W'($urandom_range(1023))
                                        : HID_W'($urandom_range(1023, 1009));
      send_expert(n == 0, tokens, hidden);
    end
    quiet = 1'b0;
  endtask

  initial begin : stimulus
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= CFG_BLOCK_ROWS;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_first_expert <= 1'b0;
    in_token_count <= '0;
    in_hidden_dim <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset sizes: block height 16, block width 1.
    send_expert(1'b1, 16'd0, 10'd0);
    send_expert(1'b0, 16'd1, 10'd1);
    send_expert(1'b0, 16'hFFFF, 10'd1023);
    send_expert(1'b0, 16'd0, 10'd1023);      // empty expert keeps the row pointer
    send_expert(1'b0, 16'hFFFF, 10'd0);      // no rows, column base still moves
    send_expert(1'b0, 16'd16, 10'd16);
    send_expert(1'b0, 16'd17, 10'd17);
    send_expert(1'b0, 16'd12345, 10'd32);
    send_expert(1'b1, 16'd100, 10'd48);      // restart in the middle of a sequence
    send_expert(1'b0, 16'd0, 10'd0);
    send_expert(1'b0, 16'd32768, 10'd1008);
    send_expert(1'b0, 16'd65534, 10'd1009);
    send_expert(1'b1, 16'hFFFF, 10'd1023);
    send_expert(1'b0, 16'd1, 10'd15);
    send_expert(1'b0, 16'd2, 10'd513);
    send_expert(1'b0, 16'h5555, 10'h2AA);
    send_expert(1'b0, 16'hAAAA, 10'h155);
    send_expert(1'b1, 16'd0, 10'd5);
    send_expert(1'b0, 16'd7, 10'd1023);
    drain(SETTLE_CYCLES);

    // Zero sizes fall back to height 16 and width 1.
    set_blocks(11'd0, 11'd0);
    send_expert(1'b1, 16'd3, 10'd20);
    send_expert(1'b0, 16'd1000, 10'd1);
    run_heavy(300);
    drain(SETTLE_CYCLES);

    set_blocks(11'd1023, 11'd1024);
    run_mixed(8);
    drain(SETTLE_CYCLES);

    set_blocks(CFG_DATA_W'($urandom_range(200, 16)), CFG_DATA_W'($urandom_range(1024, 1)));
    run_mixed(8);
    drain(SETTLE_CYCLES);

    set_blocks(CFG_DATA_W'($urandom_range(15)), CFG_DATA_W'($urandom_range(1023, 2)));
    run_mixed(8);
    drain(100);

    if (tracker.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/bcsr_pkg.sv
rtl/core/bcsr_div.sv
rtl/core/bcsr_datapath.sv
rtl/core/bcsr_ctrl.sv
rtl/core/block_csr_builder.sv
rtl/core/bcsr_checker.sv
bench/testbench.sv
